// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the subframe deframer.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);
// Consequence checked at the next clock after the condition.
`define ASSERT_NEXT(label, clk_sig, rst_sig, cond, conseq, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |=> (conseq)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, prop, msg)
`define ASSERT_NEXT(label, clk_sig, rst_sig, cond, conseq, msg)
`endif
`endif

// ===== hdl/tsdc_pkg.sv =====
// Types, constants and CRC helpers for the telemetry subframe deframer.
// No dependencies.
`default_nettype none
package tsdc_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEAD,
    PH_REPEAT,
    PH_TAIL
  } phase_t;

  localparam int SUBFRAME_BYTES = 64;
  localparam int POS_W          = $clog2(SUBFRAME_BYTES);

  localparam logic [7:0] START_LO = 8'h81;
  localparam logic [7:0] START_HI = 8'h84;
  localparam logic [7:0] SYNC_A   = 8'h55;
  localparam logic [7:0] SYNC_B   = 8'hAA;
  localparam logic [7:0] TAIL_A   = 8'hEB;
  localparam logic [7:0] TAIL_B   = 8'h90;

  localparam logic [POS_W-1:0] POS_SYNC_A = POS_W'(30);
  localparam logic [POS_W-1:0] POS_SYNC_B = POS_W'(31);
  localparam logic [POS_W-1:0] POS_TAIL_A = POS_W'(SUBFRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(SUBFRAME_BYTES - 1);

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  // Bit steps that remain after the one done in the accept cycle.
  localparam logic [2:0]  CRC_STEPS_LEFT = 3'd7;

  // One bit of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] c);
    crc_step = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
  endfunction

  function automatic logic in_crc(input logic [1:0] kind, input logic [POS_W-1:0] p);
    unique case (kind)
      2'd0: in_crc = (p >= 6'd1 && p <= 6'd10) || (p >= 6'd12 && p <= 6'd29) ||
                     (p >= 6'd34 && p <= 6'd61);
      2'd1: in_crc = (p >= 6'd1 && p <= 6'd29) || (p >= 6'd33 && p <= 6'd51) ||
                     (p >= 6'd54 && p <= 6'd61);
      default: in_crc = (p >= 6'd1 && p <= 6'd29) || (p >= 6'd33 && p <= 6'd59);
    endcase
  endfunction

  // Payload bytes of kinds 0 and 2 enter the CRC as zero.
  function automatic logic payload_zeroed(input logic [1:0] kind, input logic [POS_W-1:0] p);
    payload_zeroed = !kind[0] &&
                     ((p >= 6'd12 && p <= 6'd19) || (p >= 6'd44 && p <= 6'd51));
  endfunction

  function automatic logic [POS_W-1:0] rx_lo_pos(input logic [1:0] kind);
    unique case (kind)
      2'd0:    rx_lo_pos = 6'd11;
      2'd1:    rx_lo_pos = 6'd52;
      default: rx_lo_pos = 6'd60;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rx_hi_pos(input logic [1:0] kind);
    unique case (kind)
      2'd0:    rx_hi_pos = 6'd33;
      2'd1:    rx_hi_pos = 6'd53;
      default: rx_hi_pos = 6'd61;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hdl/telemetry_subframe_deframer_crc_top.sv =====
// Telemetry subframe deframer with bit-serial CRC-16 check and burst replay.
// Depends on tsdc_pkg and assert_macros.svh.
//
// Usage: telemetry bytes enter on the s_ group, one byte per transfer. The
// block hunts for a start byte 0x81..0x84, gathers a 64-byte subframe in an
// internal memory and checks the sync bytes 55 AA at 30-31, the repeated start
// byte at 32 and EB 90 at 62-63. A failed check drops the subframe silently.
// Input: after a byte that enters the CRC is accepted, s_tready stays low until
// the 16-bit CRC register, which advances one polynomial bit per cycle, has
// taken all of its bits; other bytes do not hold off the next transfer.
// When byte 63 of a good subframe is accepted, the 64 bytes are replayed on
// the m_ group with the type, the carried CRC and the match flag; m_tlast marks
// position 63. Each position is read from the memory, then loaded into the output
// register; a new read waits until the previous one has landed there and the
// register is free. Input transfers are held off while the replay reads the
// memory.
// A stalled receiver holds the output register; the replay then waits, and
// nothing is lost. Once the last read is issued, input transfers resume even
// while the final results still wait in the output register.
// Reset (rst, synchronous, active high) returns the block to hunting, empties
// the output register and abandons any replay; the memory is not cleared.
`default_nettype none
`include "assert_macros.svh"
module telemetry_subframe_deframer_crc_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [7:0] out_byte, [13:8] byte_pos,
                                      // [15:14] subframe_kind, [16] crc_match,
                                      // [32:17] received_check, [39:33] zero
  output logic             m_tlast    // last_of_frame
);

  localparam int PW = tsdc_pkg::POS_W;

  // Input side state.
  tsdc_pkg::phase_t phase, phase_next;
  logic [PW-1:0]    count;
  logic [1:0]       kind_held;
  logic [15:0]      crc;
  logic [2:0]       crc_left;
  logic             hdr_ok;
  logic             tail_ok;
  logic [7:0]       rx_lo;
  logic [7:0]       rx_hi;

  logic [7:0]       mem [tsdc_pkg::SUBFRAME_BYTES];

  // Replay side state.
  logic             burst_on;
  logic [PW-1:0]    rd_pos;
  logic [PW-1:0]    rd_pos_q;
  logic             rd_pend;
  logic [7:0]       rd_data;
  logic [1:0]       burst_kind;
  logic             burst_match;
  logic [15:0]      burst_rx;

  // Output register.
  logic [7:0]       out_byte;
  logic [PW-1:0]    out_pos;
  logic [1:0]       out_kind;
  logic             out_match;
  logic [15:0]      out_rx;
  logic             out_last;

  // Decode of the incoming byte.
  logic             accept;
  logic             is_start;
  logic [7:0]       start_off;
  logic [1:0]       byte_kind;
  logic [7:0]       start_code;
  logic             start_now;
  logic             store_cont;
  logic             burst_go;
  logic             wr_en;
  logic [PW-1:0]    wr_pos;
  logic [1:0]       kind_use;
  logic [15:0]      crc_base;
  logic             crc_feed;
  logic [7:0]       feed_byte;
  logic             rd_issue;

  assign s_tready   = (crc_left == 3'd0) && !burst_on;
  assign accept     = s_tvalid && s_tready;
  assign is_start   = (s_tdata >= tsdc_pkg::START_LO) && (s_tdata <= tsdc_pkg::START_HI);
  assign start_off  = s_tdata - tsdc_pkg::START_LO;
  assign byte_kind  = start_off[1:0];
  assign start_code = tsdc_pkg::START_LO + {6'd0, kind_held};

  // Next phase of the framing state machine.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      tsdc_pkg::PH_HUNT: begin
        if (start_now) phase_next = tsdc_pkg::PH_HEAD;
      end
      tsdc_pkg::PH_HEAD: begin
        if (accept && count == tsdc_pkg::POS_SYNC_B) begin
          phase_next = (hdr_ok && s_tdata == tsdc_pkg::SYNC_B) ? tsdc_pkg::PH_REPEAT
                                                                 : tsdc_pkg::PH_HUNT;
        end
      end
      tsdc_pkg::PH_REPEAT: begin
        if (store_cont) phase_next = tsdc_pkg::PH_TAIL;
        else if (start_now) phase_next = tsdc_pkg::PH_HEAD;
        else if (accept) phase_next = tsdc_pkg::PH_HUNT;
      end
      tsdc_pkg::PH_TAIL: begin
        if (accept && count == tsdc_pkg::POS_LAST) phase_next = tsdc_pkg::PH_HUNT;
      end
      default: phase_next = tsdc_pkg::PH_HUNT;
    endcase
  end

  // Actions of the framing state machine. A wrong repeated start byte is
  // looked at again as a possible new start byte.
  always_comb begin
    start_now  = 1'b0;
    store_cont = 1'b0;
    burst_go   = 1'b0;
    if (accept) begin
      unique case (phase)
        tsdc_pkg::PH_HUNT: start_now = is_start;
        tsdc_pkg::PH_HEAD: store_cont = 1'b1;
        tsdc_pkg::PH_REPEAT: begin
          if (s_tdata == start_code) store_cont = 1'b1;
          else start_now = is_start;
        end
        tsdc_pkg::PH_TAIL: begin
          store_cont = 1'b1;
          burst_go   = (count == tsdc_pkg::POS_LAST) && tail_ok &&
                       (s_tdata == tsdc_pkg::TAIL_B);
        end
        default: ;
      endcase
    end
  end

  assign wr_en     = start_now || store_cont;
  assign wr_pos    = start_now ? '0 : count;
  assign kind_use  = start_now ? byte_kind : kind_held;
  assign crc_base  = start_now ? tsdc_pkg::CRC_INIT : crc;
  assign crc_feed  = wr_en && tsdc_pkg::in_crc(kind_use, wr_pos);
  assign feed_byte = tsdc_pkg::payload_zeroed(kind_use, wr_pos) ? 8'h00 : s_tdata;

  // Framing registers and the bit-serial CRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= tsdc_pkg::PH_HUNT;
      count     <= '0;
      kind_held <= 2'd0;
      crc       <= tsdc_pkg::CRC_INIT;
      crc_left  <= 3'd0;
      hdr_ok    <= 1'b0;
      tail_ok   <= 1'b0;
    end else begin
      phase <= phase_next;
      if (start_now) begin
        kind_held <= byte_kind;
        count     <= PW'(1);
      end else if (store_cont) begin
        count <= count + PW'(1);
      end
      if (wr_en && wr_pos == tsdc_pkg::POS_SYNC_A) hdr_ok <= (s_tdata == tsdc_pkg::SYNC_A);
      if (wr_en && wr_pos == tsdc_pkg::POS_TAIL_A) tail_ok <= (s_tdata == tsdc_pkg::TAIL_A);
      if (crc_feed) begin
        crc      <= tsdc_pkg::crc_step(crc_base ^ {feed_byte, 8'h00});
        crc_left <= tsdc_pkg::CRC_STEPS_LEFT;
      end else if (start_now) begin
        crc <= tsdc_pkg::CRC_INIT;
      end else if (crc_left != 3'd0) begin
        crc      <= tsdc_pkg::crc_step(crc);
        crc_left <= crc_left - 3'd1;
      end
    end
  end

  // The carried CRC is picked off as its bytes go by.
  always_ff @(posedge clk) begin
    if (wr_en && wr_pos == tsdc_pkg::rx_lo_pos(kind_use)) rx_lo <= s_tdata;
    if (wr_en && wr_pos == tsdc_pkg::rx_hi_pos(kind_use)) rx_hi <= s_tdata;
  end

  // Subframe memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_pos] <= s_tdata;
    if (rd_issue) rd_data <= mem[rd_pos];
  end

  // A read is issued only when the output register will be free to take it.
  assign rd_issue = burst_on && !rd_pend && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_on <= 1'b0;
      rd_pend  <= 1'b0;
      rd_pos   <= '0;
    end else begin
      rd_pend <= rd_issue;
      if (burst_go) begin
        burst_on <= 1'b1;
        rd_pos   <= '0;
      end else if (rd_issue) begin
        rd_pos <= rd_pos + PW'(1);
        if (rd_pos == tsdc_pkg::POS_LAST) burst_on <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) rd_pos_q <= rd_pos;
    if (burst_go) begin
      burst_kind  <= kind_held;
      burst_rx    <= {rx_hi, rx_lo};
      burst_match <= ({rx_hi, rx_lo} == crc);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rd_pend) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      out_byte  <= rd_data;
      out_pos   <= rd_pos_q;
      out_kind  <= burst_kind;
      out_match <= burst_match;
      out_rx    <= burst_rx;
      out_last  <= (rd_pos_q == tsdc_pkg::POS_LAST);
    end
  end

  assign m_tdata = {7'd0, out_rx, out_match, out_kind, out_pos, out_byte};
  assign m_tlast = out_last;

  `ASSERT_ALWAYS(a_read_lands_in_free_reg, clk, rst, rd_pend |-> !m_tvalid, "read data has no free output register")
  `ASSERT_ALWAYS(a_burst_after_crc_done, clk, rst, burst_go |-> (crc_left == 3'd0 && phase == tsdc_pkg::PH_TAIL), "burst started with CRC unfinished")
  `ASSERT_ALWAYS(a_no_input_during_replay, clk, rst, burst_on |-> !accept, "input transfer during replay")
  `ASSERT_ALWAYS(a_last_at_final_pos, clk, rst, (m_tvalid && m_tlast) |-> (out_pos == tsdc_pkg::POS_LAST), "last mark away from final position")
  `ASSERT_NEXT(a_phase_held_in_crc, clk, rst, crc_left != 3'd0, $stable(phase), "framing phase moved while CRC busy")

endmodule
`default_nettype wire
